@@ rtl/core/gpk_pkg.sv @@
package gpk_pkg;

  // Store geometry.
  localparam int MARKERS     = 4096;
  localparam int ALLELE_BITS = 16;
  localparam int STORE_BYTES = (MARKERS + 3) / 4;
  localparam int REL_W       = (MARKERS > 1) ? $clog2(MARKERS) : 1;
  localparam int BYTE_AW     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int PAIR_W      = 2 * ALLELE_BITS;

  typedef logic [ALLELE_BITS-1:0] allele_t;
  typedef logic [REL_W-1:0]       rel_t;
  typedef logic [BYTE_AW-1:0]     byte_addr_t;
  typedef logic [1:0]             code_t;

  // Field masks of the four code slots within a packed byte.
  localparam logic [7:0] SLOT_MASK [4] = '{8'h03, 8'h0c, 8'h30, 8'hc0};

  // Opcodes.
  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Configuration register indexes.
  localparam logic REG_MARKER_OFFSET = 1'b0;
  localparam logic REG_CHECK_ENABLE  = 1'b1;

  // Genotype codes.
  localparam code_t CODE_HOM_FIRST  = 2'd0;
  localparam code_t CODE_UNTYPED    = 2'd1;
  localparam code_t CODE_HET        = 2'd2;
  localparam code_t CODE_HOM_SECOND = 2'd3;

  // Typed counts.
  localparam logic [1:0] TYPED_NONE = 2'd0;
  localparam logic [1:0] TYPED_BOTH = 2'd2;

  // Result status.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HALF  = 2'd1;
  localparam logic [1:0] ST_THIRD = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Everything the decision logic hands back to the controller.
  typedef struct packed {
    allele_t     allele_a;
    allele_t     allele_b;
    code_t       code;
    logic [1:0]  typed;
    logic [1:0]  status;
    logic        pair_we;
    logic [PAIR_W-1:0] pair_wdata;
    logic        byte_we;
    logic [7:0]  byte_wdata;
  } dec_t;

endpackage

@@ rtl/core/gpk_ram.sv @@
module gpk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/gpk_decide.sv @@
module gpk_decide (
  input  logic                       opcode_i,
  input  logic                       out_of_range_i,
  input  logic                       check_en_i,
  input  gpk_pkg::allele_t           a1_i,
  input  gpk_pkg::allele_t           a2_i,
  input  logic [gpk_pkg::PAIR_W-1:0] pair_i,
  input  logic [7:0]                 byte_i,
  input  logic [1:0]                 slot_i,
  output gpk_pkg::dec_t              dec_o
);
  import gpk_pkg::*;

  allele_t    tab_first;
  allele_t    tab_second;
  allele_t    new_first;
  allele_t    new_second;
  code_t      cur_code;
  code_t      set_code;
  logic [1:0] set_status;
  logic [2:0] shamt;
  logic [7:0] keep_bits;

  assign tab_first  = pair_i[ALLELE_BITS-1:0];
  assign tab_second = pair_i[PAIR_W-1:ALLELE_BITS];
  assign shamt      = {slot_i, 1'b0};
  assign cur_code   = code_t'((byte_i & SLOT_MASK[slot_i]) >> shamt);
  assign keep_bits  = byte_i & ~SLOT_MASK[slot_i];

  // Learn the alleles of the marker as the set item would leave them.
  always_comb begin
    new_first  = tab_first;
    new_second = tab_second;
    if (tab_first == '0) begin
      new_first = a1_i;
      if ((a1_i != a2_i) && (tab_second == '0)) begin
        new_second = a2_i;
      end
    end else if (tab_second == '0) begin
      if (tab_first != a1_i) begin
        new_second = a1_i;
      end else if (a1_i != a2_i) begin
        new_second = a2_i;
      end
    end
  end

  always_comb begin
    set_status = ST_OK;
    if (check_en_i) begin
      if ((a1_i == '0) || (a2_i == '0)) begin
        set_status = ST_HALF;
      end else if (((a1_i != new_first) && (a1_i != new_second)) ||
                   ((a2_i != new_first) && (a2_i != new_second))) begin
        set_status = ST_THIRD;
      end
    end
    if (a1_i != a2_i) begin
      set_code = CODE_HET;
    end else if (a1_i == new_first) begin
      set_code = CODE_HOM_FIRST;
    end else begin
      set_code = CODE_HOM_SECOND;
    end
  end

  always_comb begin
    dec_o            = '0;
    dec_o.pair_wdata = {new_second, new_first};
    if (out_of_range_i) begin
      dec_o.status = ST_RANGE;
    end else if (opcode_i == OP_GET) begin
      dec_o.code  = cur_code;
      dec_o.typed = (cur_code == CODE_UNTYPED) ? TYPED_NONE : TYPED_BOTH;
      case (cur_code)
        CODE_HOM_FIRST: begin
          dec_o.allele_a = tab_first;
          dec_o.allele_b = tab_first;
        end
        CODE_HET: begin
          dec_o.allele_a = tab_first;
          dec_o.allele_b = tab_second;
        end
        CODE_HOM_SECOND: begin
          dec_o.allele_a = tab_second;
          dec_o.allele_b = tab_second;
        end
        default: begin
          dec_o.allele_a = '0;
          dec_o.allele_b = '0;
        end
      endcase
    end else if ((a1_i == '0) && (a2_i == '0)) begin
      dec_o.code       = CODE_UNTYPED;
      dec_o.byte_we    = 1'b1;
      dec_o.byte_wdata = keep_bits | (8'(CODE_UNTYPED) << shamt);
    end else begin
      dec_o.status = set_status;
      if (set_status == ST_OK) begin
        dec_o.code       = set_code;
        dec_o.pair_we    = 1'b1;
        dec_o.byte_we    = 1'b1;
        dec_o.byte_wdata = keep_bits | (8'(set_code) << shamt);
      end
    end
  end

endmodule

@@ rtl/core/biallelic_genotype_packer_unit.sv @@
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  opcode, marker, first_allele, second_allele
// out_      output     out_valid/out_stall  allele_a, allele_b, genotype_code,
//                                           typed_count, status
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// Both stores are read in the accepting cycle; in S_EXEC the result is decided from
// the registered read data and written back; in_stall stays high until the item retires.
// After reset a clearing pass zeroes all MARKERS (4096) table entries and every store
// byte, with in_stall high throughout; configuration writes are still taken.
// A stalled output holds its result, and the pending item waits with its write-back until
// the output register is free, so no state changes ahead of its result.
module biallelic_genotype_packer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_marker,
  input  logic [15:0] in_first_allele,
  input  logic [15:0] in_second_allele,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_allele_a,
  output logic [15:0] out_allele_b,
  output logic [1:0]  out_genotype_code,
  output logic [1:0]  out_typed_count,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import gpk_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0] marker_offset_r;
  logic        check_enable_r;

  // Clearing pass counter.
  rel_t clr_cnt_r, clr_cnt_nxt;

  // The transaction being worked on.
  logic    opcode_r;
  logic    oor_r;
  rel_t    rel_r;
  allele_t a1_r;
  allele_t a2_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_allele_a_r;
  logic [15:0] out_allele_b_r;
  code_t       out_code_r;
  logic [1:0]  out_typed_r;
  logic [1:0]  out_status_r;

  logic              accept;
  logic              retire;
  logic [16:0]       rel_full;
  rel_t              rel_in;
  logic              oor_in;
  logic [PAIR_W-1:0] pair_rdata;
  logic [7:0]        byte_rdata;
  dec_t              dec;

  logic              pair_we;
  rel_t              pair_waddr;
  logic [PAIR_W-1:0] pair_wdata;
  logic              byte_we;
  byte_addr_t        byte_waddr;
  logic [7:0]        byte_wdata;

  // The marker is relative to the offset; a borrow also lands above the store size.
  assign rel_full = {1'b0, in_marker} - {1'b0, marker_offset_r};
  assign oor_in   = (rel_full >= 17'(MARKERS));
  assign rel_in   = rel_t'(rel_full);

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // The pending item retires when the output register can take its result.
  assign retire   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  gpk_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (MARKERS)
  ) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .re    (accept),
    .raddr (rel_in),
    .rdata (pair_rdata)
  );

  gpk_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_code_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (byte_wdata),
    .re    (accept),
    .raddr (byte_addr_t'(rel_in >> 2)),
    .rdata (byte_rdata)
  );

  gpk_decide u_decide (
    .opcode_i       (opcode_r),
    .out_of_range_i (oor_r),
    .check_en_i     (check_enable_r),
    .a1_i           (a1_r),
    .a2_i           (a2_r),
    .pair_i         (pair_rdata),
    .byte_i         (byte_rdata),
    .slot_i         (rel_r[1:0]),
    .dec_o          (dec)
  );

  // The write ports serve the clearing pass, then the write-back of each item.
  always_comb begin
    if (state_r == S_CLEAR) begin
      pair_we    = 1'b1;
      pair_waddr = clr_cnt_r;
      pair_wdata = '0;
      byte_we    = 1'b1;
      byte_waddr = byte_addr_t'(clr_cnt_r >> 2);
      byte_wdata = '0;
    end else begin
      pair_we    = retire && dec.pair_we;
      pair_waddr = rel_r;
      pair_wdata = dec.pair_wdata;
      byte_we    = retire && dec.byte_we;
      byte_waddr = byte_addr_t'(rel_r >> 2);
      byte_wdata = dec.byte_wdata;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == rel_t'(MARKERS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (retire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (retire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
      marker_offset_r <= '0;
      check_enable_r  <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MARKER_OFFSET: marker_offset_r <= cfg_wdata;
          REG_CHECK_ENABLE:  check_enable_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_r <= in_opcode;
      oor_r    <= oor_in;
      rel_r    <= rel_in;
      a1_r     <= allele_t'(in_first_allele);
      a2_r     <= allele_t'(in_second_allele);
    end
    if (retire) begin
      out_allele_a_r <= 16'(dec.allele_a);
      out_allele_b_r <= 16'(dec.allele_b);
      out_code_r     <= dec.code;
      out_typed_r    <= dec.typed;
      out_status_r   <= dec.status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_allele_a      = out_allele_a_r;
  assign out_allele_b      = out_allele_b_r;
  assign out_genotype_code = out_code_r;
  assign out_typed_count   = out_typed_r;
  assign out_status        = out_status_r;

endmodule

@@ tb/tb_biallelic_genotype_packer_unit.sv @@
`timescale 1ns / 1ps

module tb_biallelic_genotype_packer_unit;
  import gpk_pkg::*;

  // The run is ended by force if it goes on beyond this many cycles. The slowest
  // correct run is the clearing pass after reset plus roughly a thousand
  // transactions, slowed at worst by sender gaps and heavy receiver stalls.
  localparam int CYCLE_LIMIT = 400000;

  // Number of random transactions in each of the four random phases.
  localparam int PHASE_ITEMS = 260;

  // Markers touched by the well-formed random traffic of one phase. The window
  // is kept small so that every marker sees many sets and gets. This way
  // learning, third alleles and overwrites all come up often.
  localparam int WINDOW = 32;

  // One expected or observed result, with one field per output port.
  typedef struct packed {
    allele_t    allele_a;
    allele_t    allele_b;
    code_t      code;
    logic [1:0] typed;
    logic [1:0] status;
  } genotype_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [15:0] in_marker;
  logic [15:0] in_first_allele;
  logic [15:0] in_second_allele;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_allele_a;
  logic [15:0] out_allele_b;
  logic [1:0]  out_genotype_code;
  logic [1:0]  out_typed_count;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  biallelic_genotype_packer_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_marker         (in_marker),
    .in_first_allele   (in_first_allele),
    .in_second_allele  (in_second_allele),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_allele_a      (out_allele_a),
    .out_allele_b      (out_allele_b),
    .out_genotype_code (out_genotype_code),
    .out_typed_count   (out_typed_count),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Our own image of the block's state. The configuration is mirrored as it is
  // written. The allele table is held as two arrays of learned ids. The packed
  // store is held as one 2-bit code per marker, which gives the same behaviour
  // as four codes to a byte because each set only touches its own slot.
  logic [15:0] cur_offset;
  logic        checking_on;
  allele_t     learned_first  [MARKERS];
  allele_t     learned_second [MARKERS];
  code_t       stored_code    [MARKERS];

  // Results that have been predicted but not yet seen, oldest first.
  genotype_result_t pending_genotypes [$];

  // Alleles drawn on by the well-formed random traffic. The first two entries
  // are common and the last entry is rare, so that it tends to turn up as a
  // third allele.
  allele_t allele_pool [4];

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 1;
  logic        valid_held = 1'b0;
  int          stall_mode = 0;
  int          stall_left = 0;
  genotype_result_t seen_result;
  genotype_result_t wanted_result;

  // Works out the result of one accepted transaction and updates the mirrored
  // state in the same way as the block is meant to.
  function automatic genotype_result_t predict_genotype(input logic op,
                                                        input logic [15:0] marker,
                                                        input allele_t a1,
                                                        input allele_t a2);
    genotype_result_t r;
    logic [16:0]      rel_wide;
    rel_t             rel;
    allele_t          pf;
    allele_t          ps;
    code_t            c;
    r = '0;
    rel_wide = {1'b0, marker} - {1'b0, cur_offset};
    if (marker < cur_offset || rel_wide >= MARKERS) begin
      r.status = ST_RANGE;
    end else begin
      rel = rel_wide[REL_W-1:0];
      pf  = learned_first[rel];
      ps  = learned_second[rel];
      c   = stored_code[rel];
      if (op == OP_GET) begin
        r.code = c;
        case (c)
          CODE_HOM_FIRST: begin
            r.allele_a = pf;
            r.allele_b = pf;
          end
          CODE_HET: begin
            r.allele_a = pf;
            r.allele_b = ps;
          end
          CODE_HOM_SECOND: begin
            r.allele_a = ps;
            r.allele_b = ps;
          end
          default: begin
            r.allele_a = '0;
            r.allele_b = '0;
          end
        endcase
        r.typed = (c == CODE_UNTYPED) ? TYPED_NONE : TYPED_BOTH;
      end else if (a1 == '0 && a2 == '0) begin
        // An untyped set writes its code and leaves the table alone.
        r.code = CODE_UNTYPED;
        stored_code[rel] = CODE_UNTYPED;
      end else begin
        // The table learns the alleles in the order in which they first appear.
        if (pf == '0) begin
          pf = a1;
          if (a1 != a2 && ps == '0) begin
            ps = a2;
          end
        end else if (ps == '0) begin
          if (pf != a1) begin
            ps = a1;
          end else if (a1 != a2) begin
            ps = a2;
          end
        end
        // A half-typed genotype is reported in preference to a third allele.
        if (checking_on) begin
          if (a1 == '0 || a2 == '0) begin
            r.status = ST_HALF;
          end else if ((a1 != pf && a1 != ps) || (a2 != pf && a2 != ps)) begin
            r.status = ST_THIRD;
          end
        end
        if (r.status == ST_OK) begin
          if (a1 != a2) begin
            r.code = CODE_HET;
          end else if (a1 == pf) begin
            r.code = CODE_HOM_FIRST;
          end else begin
            r.code = CODE_HOM_SECOND;
          end
          learned_first[rel]  = pf;
          learned_second[rel] = ps;
          stored_code[rel]    = r.code;
        end
      end
    end
    return r;
  endfunction

  function automatic allele_t pool_allele();
    int p;
    p = $urandom_range(0, 9);
    if (p < 4) begin
      return allele_pool[0];
    end else if (p < 8) begin
      return allele_pool[1];
    end else if (p < 9) begin
      return allele_pool[2];
    end else begin
      return allele_pool[3];
    end
  endfunction

  // Offers one transaction and waits until the block takes it. Every task is
  // entered and left just after a rising edge. The valid is lowered only when
  // a real gap follows, so it is never lowered and raised in the same step.
  task automatic send_genotype(input logic op, input logic [15:0] marker,
                               input allele_t a1, input allele_t a2);
    int gap;
    in_valid         <= 1'b1;
    valid_held       = 1'b1;
    in_opcode        <= op;
    in_marker        <= marker;
    in_first_allele  <= a1;
    in_second_allele <= a2;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_genotypes.push_back(predict_genotype(op, marker, a1, a2));
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid   <= 1'b0;
        valid_held = 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Now and then a long burst runs with no idling on the sender side.
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
    end
  endtask

  // Lets the block run dry. Every transaction gives exactly one result, so the
  // block is idle once nothing is pending. The write-back of each item happens
  // as its result enters the output register, so it is done by then as well.
  task automatic settle_pipeline();
    if (valid_held) begin
      in_valid   <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_genotypes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes a register and mirrors it. This is only called while the block is idle.
  task automatic write_register(input logic idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_MARKER_OFFSET) begin
      cur_offset = data;
    end else begin
      checking_on = data[0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // This part relies on the reset values: offset zero and checking on. It covers
  // a marker that was never written, untyped sets, learning of both alleles,
  // all four codes, half-typed and third-allele errors, and the top end of the range.
  task automatic test_power_on_defaults();
    send_genotype(OP_GET, 16'd5,    16'h0000, 16'h0000);
    send_genotype(OP_SET, 16'd1,    16'h0000, 16'h0000);
    send_genotype(OP_GET, 16'd1,    16'hFFFF, 16'hFFFF);
    send_genotype(OP_SET, 16'd2,    16'hFFFF, 16'hFFFF);
    send_genotype(OP_SET, 16'd2,    16'h0001, 16'hFFFF);
    send_genotype(OP_SET, 16'd2,    16'h0001, 16'h0001);
    send_genotype(OP_GET, 16'd2,    16'h0000, 16'h0000);
    send_genotype(OP_SET, 16'd2,    16'h0007, 16'h0001);
    send_genotype(OP_SET, 16'd3,    16'h0005, 16'h0000);
    send_genotype(OP_SET, 16'd3,    16'h0000, 16'h0005);
    send_genotype(OP_SET, 16'd4095, 16'h8000, 16'h0001);
    send_genotype(OP_GET, 16'd4095, 16'h0000, 16'h0000);
    send_genotype(OP_SET, 16'd4096, 16'h0001, 16'h0001);
    send_genotype(OP_GET, 16'hFFFF, 16'h0000, 16'h0000);
    send_genotype(OP_SET, 16'd2,    16'h0000, 16'h0000);
    send_genotype(OP_GET, 16'd2,    16'h0000, 16'h0000);
    settle_pipeline();
  endtask

  // With checking off, half-typed genotypes and third alleles are learned and
  // coded as they come. The upper bits of the enable write should be ignored.
  task automatic test_checking_disabled();
    write_register(REG_CHECK_ENABLE, 16'hFFFE);
    write_register(REG_MARKER_OFFSET, 16'h1000);
    send_genotype(OP_SET, 16'h1005, 16'h0009, 16'h0000);
    send_genotype(OP_GET, 16'h1005, 16'h0000, 16'h0000);
    send_genotype(OP_SET, 16'h1006, 16'h0000, 16'h0004);
    send_genotype(OP_SET, 16'h1005, 16'h000B, 16'h000B);
    send_genotype(OP_SET, 16'h1005, 16'h000C, 16'h000D);
    send_genotype(OP_GET, 16'h1005, 16'h0000, 16'h0000);
    send_genotype(OP_SET, 16'h0FFF, 16'h0003, 16'h0003);
    send_genotype(OP_SET, 16'h1FFF, 16'h0003, 16'h0003);
    send_genotype(OP_SET, 16'h2000, 16'h0003, 16'h0003);
    settle_pipeline();
  endtask

  // This covers the largest offset, where only the top marker is held, and an
  // offset of one, where marker zero falls below the range.
  task automatic test_offset_extremes();
    write_register(REG_CHECK_ENABLE, {15'($urandom), 1'b1});
    write_register(REG_MARKER_OFFSET, 16'hFFFF);
    send_genotype(OP_GET, 16'hFFFF, 16'h0000, 16'h0000);
    send_genotype(OP_SET, 16'hFFFE, 16'h0002, 16'h0002);
    send_genotype(OP_SET, 16'hFFFF, 16'h0006, 16'h0006);
    settle_pipeline();
    write_register(REG_MARKER_OFFSET, 16'h0001);
    send_genotype(OP_GET, 16'h0000, 16'h0000, 16'h0000);
    send_genotype(OP_GET, 16'd4096, 16'h0000, 16'h0000);
    send_genotype(OP_GET, 16'd4097, 16'h0000, 16'h0000);
    settle_pipeline();
  endtask

  // Builds one random transaction. Most of them are well-formed sets and gets on
  // a small window of markers, drawing on a small allele pool. The rest are
  // untyped or half-typed genotypes, markers at the edges of the range, and
  // fully random noise.
  task automatic random_genotype_item(input int base);
    int          kind;
    logic        op;
    logic [15:0] marker;
    allele_t     a1;
    allele_t     a2;
    kind   = $urandom_range(0, 99);
    op     = ($urandom_range(0, 99) < 35) ? OP_GET : OP_SET;
    marker = cur_offset + 16'(base) + 16'($urandom_range(0, WINDOW - 1));
    a1     = pool_allele();
    a2     = pool_allele();
    if (kind < 8) begin
      op     = 1'($urandom_range(0, 1));
      marker = 16'($urandom);
      a1     = allele_t'($urandom);
      a2     = allele_t'($urandom);
    end else if (kind < 12) begin
      case ($urandom_range(0, 2))
        0:       marker = cur_offset - 16'd1;
        1:       marker = cur_offset + 16'(MARKERS - 1);
        default: marker = cur_offset + 16'(MARKERS);
      endcase
    end else if (kind < 20) begin
      a1 = '0;
      a2 = '0;
    end else if (kind < 26) begin
      if ($urandom_range(0, 1) == 0) begin
        a1 = '0;
      end else begin
        a2 = '0;
      end
    end
    send_genotype(op, marker, a1, a2);
  endtask

  task automatic run_random_phase(input logic [15:0] offset, input logic check);
    int base;
    write_register(REG_MARKER_OFFSET, offset);
    write_register(REG_CHECK_ENABLE, {15'($urandom), check});
    foreach (allele_pool[i]) begin
      allele_pool[i] = allele_t'($urandom_range(1, 16'hFFFF));
    end
    case ($urandom_range(0, 3))
      0:       base = 0;
      1:       base = MARKERS - WINDOW;
      default: base = $urandom_range(0, MARKERS - WINDOW);
    endcase
    repeat (PHASE_ITEMS) random_genotype_item(base);
    settle_pipeline();
  endtask

  // There are four random phases. They cover the lowest offset, an offset where
  // the range reaches the top of the marker space, and random offsets. Checking
  // is switched on and off between them.
  task automatic test_random_streams();
    run_random_phase(16'h0000, 1'b1);
    run_random_phase(16'($urandom_range(1, 16'hEFFF)), 1'b0);
    run_random_phase(16'hF000, 1'b1);
    run_random_phase(16'($urandom_range(1, 16'hEFFF)), 1'b1);
  endtask

  // Checks each result against the oldest pending prediction, and drives the
  // receiver's stall. The stall follows modes that change at random. They are
  // no stalling at all, light random stalls, heavy random stalls and a regular
  // square wave. A transaction leaves the block at an edge where out_valid is
  // high and out_stall is low. The values sampled here are the ones from before
  // the edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen_result = {out_allele_a, out_allele_b, out_genotype_code, out_typed_count,
                     out_status};
      if (pending_genotypes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with nothing pending: a=%h b=%h code=%0d typed=%0d st=%0d",
                   $realtime, out_allele_a, out_allele_b, out_genotype_code,
                   out_typed_count, out_status);
        end
      end else begin
        wanted_result = pending_genotypes.pop_front();
        if (seen_result !== wanted_result) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: expected a=%h b=%h code=%0d typed=%0d st=%0d", $realtime,
                     wanted_result.allele_a, wanted_result.allele_b,
                     wanted_result.code, wanted_result.typed, wanted_result.status);
            $display("%0t:   actual a=%h b=%h code=%0d typed=%0d st=%0d", $realtime,
                     out_allele_a, out_allele_b, out_genotype_code, out_typed_count,
                     out_status);
          end
        end
      end
    end
    if (stall_left <= 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 80);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cycle_count[2];
    endcase
  end

  // This is the watchdog. It also covers the clearing pass that runs after reset.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_opcode        <= OP_SET;
    in_marker        <= '0;
    in_first_allele  <= '0;
    in_second_allele <= '0;
    out_stall        <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_MARKER_OFFSET;
    cfg_wdata        <= '0;
    cur_offset  = 16'h0000;
    checking_on = 1'b1;
    foreach (stored_code[i]) begin
      learned_first[i]  = '0;
      learned_second[i] = '0;
      stored_code[i]    = CODE_HOM_FIRST;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The first transactions simply wait behind in_stall while the block
    // clears its table and store.
    test_power_on_defaults();
    test_checking_disabled();
    test_offset_extremes();
    test_random_streams();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_genotypes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
